/* rtl/rbb_pkg.sv */
// Shared types and constants for the region box blur block.
// Pixel, line store word and window column types, register indexes, divide-by-9 constants.
// Used by rbb_cell, rbb_line_buf and region_box_blur_3x3.
`timescale 1ns / 1ps

package rbb_pkg;

  // Default store and counter sizes
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Configuration port
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 13;
  localparam int unsigned NUM_REGS = 6;

  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_REGION_TOP    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_REGION_LEFT   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_REGION_BOTTOM = 3'd4;
  localparam logic [CFG_AW-1:0] REG_REGION_RIGHT  = 3'd5;

  localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;

  // floor(s / 9) = (s * 3641) >> 15 for every s below 32768
  localparam logic [11:0] DIV9_MUL   = 12'd3641;
  localparam int unsigned DIV9_SHIFT = 15;

  // One pixel, red in the lowest byte
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

  // One window column: index 0 above, 1 middle, 2 below
  typedef pix_t [2:0] col_t;

  // Line store word: two rows of one column
  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } lb_word_t;

  // Per-column colour sums (at most 3 * 255)
  typedef struct packed {
    logic [9:0] b;
    logic [9:0] g;
    logic [9:0] r;
  } csum_t;

  // Whole-window colour sums (at most 9 * 255)
  typedef struct packed {
    logic [11:0] b;
    logic [11:0] g;
    logic [11:0] r;
  } tsum_t;

  // Control for one window cell
  typedef struct packed {
    logic       shift;
    logic [2:0] keep;
  } cell_ctrl_t;

endpackage

/* rtl/rbb_cell.sv */
// One column cell of the 3x3 window: holds three pixels, loads its neighbor's column.
// Produces the masked colour sums of its column. Depends on rbb_pkg.
`timescale 1ns / 1ps

module rbb_cell (
  input  logic                clk_i,
  input  rbb_pkg::cell_ctrl_t ctrl_i,
  input  rbb_pkg::col_t       col_i,
  output rbb_pkg::col_t       col_o,
  output rbb_pkg::csum_t      sum_o
);
  import rbb_pkg::*;

  col_t  col_q;
  csum_t sum;

  // Take the neighbor's column on every shift
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      col_q <= col_i;
    end
  end

  // Add the pixels that lie inside both image and rectangle
  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      if (ctrl_i.keep[k]) begin
        sum.r = sum.r + 10'(col_q[k].r);
        sum.g = sum.g + 10'(col_q[k].g);
        sum.b = sum.b + 10'(col_q[k].b);
      end
    end
  end

  assign col_o = col_q;
  assign sum_o = sum;

endmodule

/* rtl/rbb_line_buf.sv */
// Line store for two image rows, one word per column, registered read.
// Forwards a write that lands on the address read in the same cycle. Depends on rbb_pkg.
`timescale 1ns / 1ps

module rbb_line_buf #(
  parameter int unsigned DEPTH = rbb_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  rbb_pkg::lb_word_t        wr_data_i,
  output rbb_pkg::lb_word_t        rd_data_o
);
  import rbb_pkg::*;

  lb_word_t mem_q [DEPTH];
  lb_word_t rdata_q;
  lb_word_t byp_data_q;
  logic     byp_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, with the colliding write captured for forwarding
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem_q[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rdata_q;

endmodule

/* rtl/region_box_blur_3x3.sv */
// Region box blur 3x3: raster pixels in, blurred inside a rectangle, others passed.
// Throughput: one item per clock while the skid stage is empty. A result passes stages B to
// E and the output register once the item one row plus one pixel later completes its window.
// The line store's registered read and the three-cell window set the pipeline depth.
// Reset clears counters, pipeline and output valids and restores register defaults;
// line store contents stay undefined until written and need no clearing pass.
`timescale 1ns / 1ps

module region_box_blur_3x3 #(
  parameter int unsigned MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rbb_pkg::CFG_AW-1:0] cfg_index_i,
  input  logic [rbb_pkg::CFG_DW-1:0] cfg_data_i,
  // Pixel input
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
  input  logic                       s_axis_tuser,  // flush
  // Pixel output
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                       m_axis_tlast   // frame_last
);
  import rbb_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned CSW = ((WW > 12) ? WW : 12) + 1;
  localparam int unsigned RSW = ((RW > 13) ? RW : 13) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [11:0] cfg_width_q, cfg_left_q, cfg_right_q;
  logic [12:0] cfg_height_q, cfg_top_q, cfg_bottom_q;
  logic        cfg_hit;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    case (cfg_index_i)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_REGION_TOP,
      REG_REGION_LEFT, REG_REGION_BOTTOM, REG_REGION_RIGHT: cfg_hit = cfg_valid_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= IMAGE_WIDTH_RST;
      cfg_height_q <= IMAGE_HEIGHT_RST;
      cfg_top_q    <= '0;
      cfg_left_q   <= '0;
      cfg_bottom_q <= '0;
      cfg_right_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:   cfg_width_q  <= cfg_data_i[11:0];
        REG_IMAGE_HEIGHT:  cfg_height_q <= cfg_data_i;
        REG_REGION_TOP:    cfg_top_q    <= cfg_data_i;
        REG_REGION_LEFT:   cfg_left_q   <= cfg_data_i[11:0];
        REG_REGION_BOTTOM: cfg_bottom_q <= cfg_data_i;
        REG_REGION_RIGHT:  cfg_right_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to the supported range
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h_eff = RW'(1);
    end else if (32'(cfg_height_q) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(cfg_height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Input position and neighbor masks
  // ---------------------------------------------------------------------------
  logic          en;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          acc, draining, act, col_zero, emit_a, last_a;
  pix_t          pix_a;
  logic signed [RSW-1:0] nr_base;
  logic signed [RSW-1:0] nr [3];
  logic signed [CSW-1:0] nc_base;
  logic signed [CSW-1:0] nc [3];
  logic [2:0]    row_ok_a, col_ok_a;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  always_comb begin
    acc      = s_axis_tvalid && en;
    draining = row_q >= h_eff;
    act      = acc && (draining || !s_axis_tuser);
    col_zero = (col_q == '0);
    emit_a   = col_zero ? (row_q >= RW'(2)) : (row_q != '0);
    last_a   = col_zero && (row_q == h_eff + RW'(1));
    pix_a    = draining ? '0 : pix_t'(s_axis_tdata);

    // Target sits one row up (two rows up, last column, at a row start)
    nr_base = $signed(RSW'(row_q)) - (col_zero ? RSW'(3) : RSW'(2));
    nc_base = col_zero ? ($signed(CSW'(w_eff)) - CSW'(2))
                       : ($signed(CSW'(col_q)) - CSW'(2));
    for (int k = 0; k < 3; k++) begin
      nr[k] = nr_base + RSW'(k);
      nc[k] = nc_base + CSW'(k);
      row_ok_a[k] = (nr[k] >= $signed(RSW'(cfg_top_q)))
                 && (nr[k] <  $signed(RSW'(cfg_bottom_q)))
                 && (nr[k] <  $signed(RSW'(h_eff)));
      col_ok_a[k] = (nc[k] >= $signed(CSW'(cfg_left_q)))
                 && (nc[k] <  $signed(CSW'(cfg_right_q)))
                 && (nc[k] <  $signed(CSW'(w_eff)));
    end
  end

  // Advance the raster position; a register write or the frame's last output restarts it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (act) begin
      if (last_a) begin
        col_q <= '0;
        row_q <= '0;
      end else if (WW'(col_q) + WW'(1) == w_eff) begin
        col_q <= '0;
        row_q <= row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: line store read data arrives, window shifts
  // ---------------------------------------------------------------------------
  logic          vb_q, eb_q, lb_q;
  logic [CW-1:0] colb_q;
  pix_t          pixb_q;
  logic [2:0]    row_ok_b_q, col_ok_b_q;
  lb_word_t      lb_rdata, lb_wdata;
  logic          shift_b;

  assign shift_b  = en && vb_q;
  assign lb_wdata = '{upper: lb_rdata.lower, lower: pixb_q};

  rbb_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (act),
    .rd_addr_i (col_q),
    .wr_en_i   (shift_b),
    .wr_addr_i (colb_q),
    .wr_data_i (lb_wdata),
    .rd_data_o (lb_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage C: window cells hold the target's neighborhood
  // ---------------------------------------------------------------------------
  logic       vc_q, lc_q;
  logic [2:0] row_ok_c_q, col_ok_c_q;
  col_t       chain_in [3];
  col_t       cell_col [3];
  csum_t      cell_sum [3];
  cell_ctrl_t cell_ctrl [3];

  assign chain_in[0] = cell_col[1];
  assign chain_in[1] = cell_col[2];
  assign chain_in[2] = {pixb_q, lb_rdata.lower, lb_rdata.upper};

  for (genvar i = 0; i < 3; i++) begin : g_cell
    assign cell_ctrl[i].shift = shift_b;
    assign cell_ctrl[i].keep  = col_ok_c_q[i] ? row_ok_c_q : 3'b000;

    rbb_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .col_i  (chain_in[i]),
      .col_o  (cell_col[i]),
      .sum_o  (cell_sum[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Stages D and E: total the columns, then divide by nine
  // ---------------------------------------------------------------------------
  logic  vd_q, ld_q, ind_q;
  pix_t  centre_d_q;
  csum_t csum_d_q [3];
  logic  ve_q, le_q, ine_q;
  pix_t  centre_e_q;
  tsum_t tsum_e_q;
  tsum_t tsum_d;
  logic [23:0] prod_r, prod_g, prod_b;
  pix_t  res_e;

  always_comb begin
    tsum_d.r = 12'(csum_d_q[0].r) + 12'(csum_d_q[1].r) + 12'(csum_d_q[2].r);
    tsum_d.g = 12'(csum_d_q[0].g) + 12'(csum_d_q[1].g) + 12'(csum_d_q[2].g);
    tsum_d.b = 12'(csum_d_q[0].b) + 12'(csum_d_q[1].b) + 12'(csum_d_q[2].b);
  end

  always_comb begin
    prod_r = 24'(tsum_e_q.r) * 24'(DIV9_MUL);
    prod_g = 24'(tsum_e_q.g) * 24'(DIV9_MUL);
    prod_b = 24'(tsum_e_q.b) * 24'(DIV9_MUL);
    res_e  = centre_e_q;
    if (ine_q) begin
      res_e.r = prod_r[DIV9_SHIFT +: 8];
      res_e.g = prod_g[DIV9_SHIFT +: 8];
      res_e.b = prod_b[DIV9_SHIFT +: 8];
    end
  end

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en) begin
      vb_q <= act;
      vc_q <= vb_q && eb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      eb_q       <= emit_a;
      lb_q       <= last_a;
      colb_q     <= col_q;
      pixb_q     <= pix_a;
      row_ok_b_q <= row_ok_a;
      col_ok_b_q <= col_ok_a;

      lc_q       <= lb_q;
      row_ok_c_q <= row_ok_b_q;
      col_ok_c_q <= col_ok_b_q;

      ld_q       <= lc_q;
      ind_q      <= row_ok_c_q[1] && col_ok_c_q[1];
      centre_d_q <= cell_col[1][1];
      for (int i = 0; i < 3; i++) begin
        csum_d_q[i] <= cell_sum[i];
      end

      le_q       <= ld_q;
      ine_q      <= ind_q;
      centre_e_q <= centre_d_q;
      tsum_e_q   <= tsum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid stage
  // ---------------------------------------------------------------------------
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic out_last_q, skid_last_q;
  pix_t out_pix_q, skid_pix_q;
  logic take, emerge, out_load_new, out_load_skid, skid_load;

  always_comb begin
    take          = out_valid_q && m_axis_tready;
    emerge        = en && ve_q;
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    out_load_new  = 1'b0;
    out_load_skid = 1'b0;
    skid_load     = 1'b0;
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_load_skid = 1'b1;
        skid_valid_d  = 1'b0;
        out_valid_d   = 1'b1;
      end else if (emerge) begin
        out_load_new = 1'b1;
        out_valid_d  = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (emerge) begin
      skid_load    = 1'b1;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_skid) begin
      out_pix_q  <= skid_pix_q;
      out_last_q <= skid_last_q;
    end else if (out_load_new) begin
      out_pix_q  <= res_e;
      out_last_q <= le_q;
    end
    if (skid_load) begin
      skid_pix_q  <= res_e;
      skid_last_q <= le_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  a_col_in_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < w_eff)
    else $error("column counter beyond image width");

  a_row_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_eff + RW'(1))
    else $error("row counter beyond frame tail");

  a_restart_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && last_a) |=> (row_q == '0 && col_q == '0))
    else $error("frame did not restart after last output");
`endif

endmodule
